// File: hdl/lr0p_pkg.sv
package lr0p_pkg;

	localparam int NUM_STATES  = 256;
	localparam int NUM_SYMBOLS = 64;
	localparam int STACK_DEPTH = 64;
	localparam int MAX_BODY    = 15;
	localparam int MAX_CHAIN   = 62;

	localparam int ST_W    = $clog2(NUM_STATES);
	localparam int SYM_W   = $clog2(NUM_SYMBOLS);
	localparam int GA_W    = ST_W + SYM_W;
	localparam int SP_W    = $clog2(STACK_DEPTH);
	localparam int CNT_W   = SP_W + 1;
	localparam int BODY_W  = $clog2(MAX_BODY + 1);
	localparam int CHAIN_W = $clog2(MAX_CHAIN + 1);
	localparam int PROD_W  = 8;
	localparam int GOTO_DEPTH = NUM_STATES * NUM_SYMBOLS;

	localparam logic [1:0] REQ_GOTO  = 2'd0;
	localparam logic [1:0] REQ_RED   = 2'd1;
	localparam logic [1:0] REQ_TOKEN = 2'd2;

	localparam logic [1:0] EV_SHIFT  = 2'd0;
	localparam logic [1:0] EV_REDUCE = 2'd1;
	localparam logic [1:0] EV_ACCEPT = 2'd2;
	localparam logic [1:0] EV_REJECT = 2'd3;

	localparam logic [2:0] RC_NONE      = 3'd0;
	localparam logic [2:0] RC_NO_SHIFT  = 3'd1;
	localparam logic [2:0] RC_NO_GOTO   = 3'd2;
	localparam logic [2:0] RC_END       = 3'd3;
	localparam logic [2:0] RC_OVERFLOW  = 3'd4;
	localparam logic [2:0] RC_UNDERFLOW = 3'd5;

	typedef struct packed {
		logic            vld;
		logic [ST_W-1:0] target;
	} goto_ent_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [BODY_W-1:0] blen;
		logic [SYM_W-1:0]  head;
	} red_ent_t;

	typedef struct packed {
		logic            we;
		logic [GA_W-1:0] waddr;
		goto_ent_t       wdata;
		logic [GA_W-1:0] raddr;
	} goto_cmd_t;

	typedef struct packed {
		logic            we;
		logic [ST_W-1:0] waddr;
		logic            wvalid;
		red_ent_t        wdata;
		logic [ST_W-1:0] raddr;
	} red_cmd_t;

	typedef struct packed {
		logic            we;
		logic [SP_W-1:0] waddr;
		logic [ST_W-1:0] wdata;
		logic [SP_W-1:0] raddr;
	} stk_cmd_t;

endpackage

// File: hdl/lr0_shift_reduce_parser_unit.sv
// Table writes complete in the cycle they are accepted and produce no word.
// A token's shift word follows a reduce-table and a goto-table read; each
// reduction adds its reduce-table, stack and goto-table reads. Accept and
// pop-underflow words come from states of their own; a new word is taken
// right after. After reset the goto table is cleared, one entry a cycle,
// with busy high. The receiver cannot stall: each word shows for one cycle.
module lr0_shift_reduce_parser_unit import lr0p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [ST_W-1:0]   table_state,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [ST_W-1:0]   target_state,
	input  logic              entry_valid,
	input  logic [PROD_W-1:0] production_id,
	input  logic [BODY_W-1:0] body_length,
	input  logic [SYM_W-1:0]  head_symbol,
	input  logic              is_end,
	output logic              result_strobe,
	output logic [1:0]        event_kind,
	output logic [SYM_W-1:0]  shifted_symbol,
	output logic [PROD_W-1:0] reduced_production,
	output logic [2:0]        reject_cause,
	output logic              last
);

	goto_cmd_t       goto_cmd;
	red_cmd_t        red_cmd;
	stk_cmd_t        stk_cmd;
	goto_ent_t       goto_rdata;
	red_ent_t        red_rdata;
	logic            red_rvalid;
	logic [ST_W-1:0] stk_rdata;
	logic            clearing;

	lr0p_goto_mem u_goto (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (goto_cmd),
		.rdata    (goto_rdata),
		.clearing (clearing)
	);

	lr0p_red_tbl u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (red_cmd),
		.rdata  (red_rdata),
		.rvalid (red_rvalid)
	);

	lr0p_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.rdata  (stk_rdata)
	);

	lr0p_seq u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.clearing           (clearing),
		.req_type           (req_type),
		.table_state        (table_state),
		.symbol             (symbol),
		.target_state       (target_state),
		.entry_valid        (entry_valid),
		.production_id      (production_id),
		.body_length        (body_length),
		.head_symbol        (head_symbol),
		.is_end             (is_end),
		.goto_rdata         (goto_rdata),
		.red_rdata          (red_rdata),
		.red_rvalid         (red_rvalid),
		.stk_rdata          (stk_rdata),
		.goto_cmd           (goto_cmd),
		.red_cmd            (red_cmd),
		.stk_cmd            (stk_cmd),
		.busy               (busy),
		.result_strobe      (result_strobe),
		.event_kind         (event_kind),
		.shifted_symbol     (shifted_symbol),
		.reduced_production (reduced_production),
		.reject_cause       (reject_cause),
		.last               (last)
	);

endmodule

// File: hdl/lr0p_goto_mem.sv
module lr0p_goto_mem import lr0p_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  goto_cmd_t cmd,
	output goto_ent_t rdata,
	output logic      clearing
);

	goto_ent_t       mem [GOTO_DEPTH];
	logic [GA_W-1:0] clr_idx_q;
	logic            clearing_q;
	logic            we;
	logic [GA_W-1:0] waddr;
	goto_ent_t       wdata;
	goto_ent_t       rdata_q;

	// The clearing pass owns the write port until every entry is invalid.
	always_comb begin
		we    = clearing_q | cmd.we;
		waddr = clearing_q ? clr_idx_q : cmd.waddr;
		wdata = clearing_q ? goto_ent_t'('0) : cmd.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + GA_W'(1);
			if (clr_idx_q == {GA_W{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[cmd.raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

// File: hdl/lr0p_red_tbl.sv
module lr0p_red_tbl import lr0p_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  red_cmd_t cmd,
	output red_ent_t rdata,
	output logic     rvalid
);

	red_ent_t                mem [NUM_STATES];
	logic [NUM_STATES-1:0]   vld_q;
	red_ent_t                rdata_q;
	logic                    rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.we) begin
				vld_q[cmd.waddr] <= cmd.wvalid;
			end
			rvalid_q <= vld_q[cmd.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata_q <= mem[cmd.raddr];
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

// File: hdl/lr0p_stack.sv
module lr0p_stack import lr0p_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  stk_cmd_t        cmd,
	output logic [ST_W-1:0] rdata
);

	logic [ST_W-1:0] mem [STACK_DEPTH];
	logic [ST_W-1:0] rdata_q;
	logic            rd_bottom_q;

	// The bottom entry is never pushed and always holds state zero, so it is
	// not stored and the memory needs no clearing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_bottom_q <= 1'b1;
		end else begin
			rd_bottom_q <= (cmd.raddr == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata_q <= mem[cmd.raddr];
	end

	assign rdata = rd_bottom_q ? '0 : rdata_q;

endmodule

// File: hdl/lr0p_seq.sv
module lr0p_seq import lr0p_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clearing,
	input  logic [1:0]        req_type,
	input  logic [ST_W-1:0]   table_state,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [ST_W-1:0]   target_state,
	input  logic              entry_valid,
	input  logic [PROD_W-1:0] production_id,
	input  logic [BODY_W-1:0] body_length,
	input  logic [SYM_W-1:0]  head_symbol,
	input  logic              is_end,
	input  goto_ent_t         goto_rdata,
	input  red_ent_t          red_rdata,
	input  logic              red_rvalid,
	input  logic [ST_W-1:0]   stk_rdata,
	output goto_cmd_t         goto_cmd,
	output red_cmd_t          red_cmd,
	output stk_cmd_t          stk_cmd,
	output logic              busy,
	output logic              result_strobe,
	output logic [1:0]        event_kind,
	output logic [SYM_W-1:0]  shifted_symbol,
	output logic [PROD_W-1:0] reduced_production,
	output logic [2:0]        reject_cause,
	output logic              last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_STK,
		S_RGOTO,
		S_SGOTO,
		S_UNDER,
		S_ACC
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SYM_W-1:0]  sym;
		logic [PROD_W-1:0] prod;
		logic [2:0]        cause;
		logic              last;
	} res_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [ST_W-1:0]     top_q;
	logic [CHAIN_W-1:0]  chain_q;
	logic [SYM_W-1:0]    head_q;
	logic [SYM_W-1:0]    sym_q;
	logic                end_q;
	logic                strobe_q;
	res_t                res_q;

	logic                accept;
	logic [CNT_W-1:0]    blen_ext;
	logic [CNT_W-1:0]    cnt_after;
	logic [CNT_W-1:0]    stk_idx;
	logic                underflow;
	logic                full;

	function automatic res_t mk_res(logic [1:0] kind, logic [SYM_W-1:0] sym,
			logic [PROD_W-1:0] prod, logic [2:0] cause, logic lst);
		res_t r;
		r.kind  = kind;
		r.sym   = sym;
		r.prod  = prod;
		r.cause = cause;
		r.last  = lst;
		return r;
	endfunction

	// The body-length subtraction gives the count after the pop; a separate compare
	// flags underflow, and one less than that count addresses the uncovered state.
	always_comb begin
		accept    = (state_q == S_IDLE) && start && !clearing;
		blen_ext  = CNT_W'(red_rdata.blen);
		cnt_after = count_q - blen_ext;
		underflow = (blen_ext >= count_q);
		stk_idx   = cnt_after - CNT_W'(1);
		full      = (count_q >= CNT_W'(STACK_DEPTH));

		goto_cmd.we     = accept && (req_type == REQ_GOTO);
		goto_cmd.waddr  = {table_state, symbol};
		goto_cmd.wdata  = entry_valid ? goto_ent_t'{vld: 1'b1, target: target_state}
			: goto_ent_t'('0);
		goto_cmd.raddr  = (state_q == S_STK) ? {stk_rdata, head_q} : {top_q, sym_q};

		red_cmd.we      = accept && (req_type == REQ_RED);
		red_cmd.waddr   = table_state;
		red_cmd.wvalid  = entry_valid;
		red_cmd.wdata   = red_ent_t'{prod: production_id, blen: body_length,
			head: head_symbol};
		red_cmd.raddr   = (state_q == S_RGOTO) ? goto_rdata.target : top_q;

		stk_cmd.we      = ((state_q == S_RGOTO) || (state_q == S_SGOTO))
			&& goto_rdata.vld && !full;
		stk_cmd.waddr   = count_q[SP_W-1:0];
		stk_cmd.wdata   = goto_rdata.target;
		stk_cmd.raddr   = stk_idx[SP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= CNT_W'(1);
			top_q    <= '0;
			chain_q  <= '0;
			head_q   <= '0;
			sym_q    <= '0;
			end_q    <= 1'b0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (req_type == REQ_TOKEN)) begin
						sym_q   <= symbol;
						end_q   <= is_end;
						chain_q <= '0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (red_rvalid) begin
						if (chain_q == CHAIN_W'(MAX_CHAIN)) begin
							strobe_q <= 1'b1;
							res_q    <= mk_res(EV_REJECT, '0, '0, RC_UNDERFLOW, 1'b1);
							count_q  <= CNT_W'(1);
							top_q    <= '0;
							state_q  <= S_IDLE;
						end else begin
							chain_q  <= chain_q + CHAIN_W'(1);
							head_q   <= red_rdata.head;
							strobe_q <= 1'b1;
							res_q    <= mk_res(EV_REDUCE, '0, red_rdata.prod, RC_NONE, 1'b0);
							if (underflow) begin
								state_q <= S_UNDER;
							end else begin
								count_q <= cnt_after;
								if ((cnt_after == CNT_W'(1)) && end_q) begin
									state_q <= S_ACC;
								end else begin
									state_q <= S_STK;
								end
							end
						end
					end else if (end_q) begin
						strobe_q <= 1'b1;
						res_q    <= mk_res(EV_REJECT, '0, '0, RC_END, 1'b1);
						count_q  <= CNT_W'(1);
						top_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SGOTO;
					end
				end
				S_STK: begin
					state_q <= S_RGOTO;
				end
				S_RGOTO: begin
					if (!goto_rdata.vld || full) begin
						strobe_q <= 1'b1;
						res_q    <= mk_res(EV_REJECT, '0, '0,
							goto_rdata.vld ? RC_OVERFLOW : RC_NO_GOTO, 1'b1);
						count_q  <= CNT_W'(1);
						top_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						count_q <= count_q + CNT_W'(1);
						top_q   <= goto_rdata.target;
						state_q <= S_EVAL;
					end
				end
				S_SGOTO: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
					if (!goto_rdata.vld || full) begin
						res_q   <= mk_res(EV_REJECT, '0, '0,
							goto_rdata.vld ? RC_OVERFLOW : RC_NO_SHIFT, 1'b1);
						count_q <= CNT_W'(1);
						top_q   <= '0;
					end else begin
						res_q   <= mk_res(EV_SHIFT, sym_q, '0, RC_NONE, 1'b1);
						count_q <= count_q + CNT_W'(1);
						top_q   <= goto_rdata.target;
					end
				end
				S_UNDER: begin
					strobe_q <= 1'b1;
					res_q    <= mk_res(EV_REJECT, '0, '0, RC_UNDERFLOW, 1'b1);
					count_q  <= CNT_W'(1);
					top_q    <= '0;
					state_q  <= S_IDLE;
				end
				S_ACC: begin
					strobe_q <= 1'b1;
					res_q    <= mk_res(EV_ACCEPT, '0, '0, RC_NONE, 1'b1);
					count_q  <= CNT_W'(1);
					top_q    <= '0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy               = (state_q != S_IDLE) || clearing;
	assign result_strobe      = strobe_q;
	assign event_kind         = res_q.kind;
	assign shifted_symbol     = res_q.sym;
	assign reduced_production = res_q.prod;
	assign reject_cause       = res_q.cause;
	assign last               = res_q.last;

endmodule

// File: hdl/lr0p_checker.sv
module lr0p_checker import lr0p_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] req_type,
	input logic       result_strobe,
	input logic [1:0] event_kind,
	input logic [2:0] reject_cause,
	input logic       last
);

	// A shift always ends the work of its token.
	a_shift_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (event_kind == EV_SHIFT) |-> last)
		else $error("shift word not marked last");

	// A reject always carries a cause and ends the token.
	a_reject_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (event_kind == EV_REJECT) |-> last && (reject_cause != RC_NONE))
		else $error("reject word without cause or not last");

	// Further words follow a reduce, so the engine is still busy.
	a_reduce_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (event_kind == EV_REDUCE) |-> !last && busy)
		else $error("reduce word marked last or engine idle");

	// No word can appear in the cycle right after a request is taken.
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe)
		else $error("word shown directly after a request");

	// Table writes never produce a word and leave the engine free.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type != REQ_TOKEN) |=> !busy)
		else $error("table write left the engine busy");

endmodule

bind lr0_shift_reduce_parser_unit lr0p_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.req_type      (req_type),
	.result_strobe (result_strobe),
	.event_kind    (event_kind),
	.reject_cause  (reject_cause),
	.last          (last)
);
